// File: rtl/sng_pkg.sv
// Package for the sidechain noise gate: widths, fixed levels, reset values,
// register indexes and the structs that pass between the core and the top level.
// No dependencies.
`default_nettype none

package sng_pkg;

    // Sample and coefficient formats
    localparam int SAMPLE_W  = 24;                     // Q1.23 samples
    localparam int COEF_FRAC = 24;                     // Q1.24 unsigned coefficients
    localparam int COEF_W    = COEF_FRAC + 1;          // up to exactly 1.0
    localparam int GUARD     = 16;                     // extra filter fraction bits
    localparam int MEM_W     = SAMPLE_W + GUARD;       // filter memories, Q1.39
    localparam int DIFF_W    = MEM_W + 1;              // difference of two memories
    localparam int LO_W      = COEF_FRAC;              // low slice of a difference
    localparam int HI_W      = DIFF_W - LO_W;          // high slice of a difference
    localparam int MUL_W     = COEF_W;                 // shared multiplier operands
    localparam int PROD_W    = 2 * MUL_W;              // registered product
    localparam int ACC_W     = HI_W + COEF_W + 1;      // step magnitude accumulator

    // Configuration register file
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Register indexes, register i at byte address 4*i
    localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HP     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LP     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ATK    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REL    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OPEN   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CLOSE  = 3'd6;

    // Coefficient of exactly one
    localparam logic [COEF_W-1:0] ONE_COEF = {1'b1, {COEF_FRAC{1'b0}}};

    // Hysteresis levels in sample LSBs: -60 dBFS opens, -67 dBFS closes
    localparam logic [SAMPLE_W-1:0] OPEN_LEVEL =
        SAMPLE_W'(((1 << (SAMPLE_W - 1)) + 500) / 1000);
    localparam logic [SAMPLE_W-1:0] CLOSE_LEVEL =
        SAMPLE_W'(((1 << (SAMPLE_W - 1)) * 45 + 50000) / 100000);

    // Configuration set seen by the core
    typedef struct packed {
        logic              enable;
        logic [COEF_W-1:0] hp;
        logic [COEF_W-1:0] lp;
        logic [COEF_W-1:0] atk;
        logic [COEF_W-1:0] rel;
        logic [COEF_W-1:0] opn;
        logic [COEF_W-1:0] cls;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        enable: 1'b1,
        hp:     25'd216775,
        lp:     25'd4952955,
        atk:    25'd231410,
        rel:    25'd1589,
        opn:    25'd345910,
        cls:    25'd1942
    };

    // Result beat handed from the core to the output register
    typedef struct packed {
        logic                valid;
        logic                open;
        logic [SAMPLE_W-1:0] sample;
    } t_res;

endpackage

`default_nettype wire

// File: rtl/sng_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on sng_pkg for operand and product widths.
`default_nettype none

module sng_mul (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [sng_pkg::MUL_W-1:0]  i_a,
    input  wire logic [sng_pkg::MUL_W-1:0]  i_b,
    output logic      [sng_pkg::PROD_W-1:0] o_prod
);

    logic [sng_pkg::PROD_W-1:0] r_prod;

    // One product per enabled cycle, held until the next one
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= sng_pkg::PROD_W'(i_a) * sng_pkg::PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: rtl/sng_core.sv
// Sequencer and datapath of the noise gate: filters, envelope, hysteresis,
// gain smoothing and gain multiply, all on one shared multiplier.
// Depends on sng_pkg and sng_mul.
`default_nettype none

module sng_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sng_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_in_valid,
    input  wire logic [sng_pkg::SAMPLE_W-1:0]  i_sc,
    input  wire logic [sng_pkg::SAMPLE_W-1:0]  i_au,
    output logic                               o_ready,
    input  wire logic                          i_slot_free,
    output sng_pkg::t_res                      o_res
);

    localparam int SW = sng_pkg::SAMPLE_W;
    localparam int CW = sng_pkg::COEF_W;
    localparam int CF = sng_pkg::COEF_FRAC;
    localparam int GD = sng_pkg::GUARD;
    localparam int MW = sng_pkg::MEM_W;
    localparam int DW = sng_pkg::DIFF_W;
    localparam int LW = sng_pkg::LO_W;
    localparam int UW = sng_pkg::MUL_W;
    localparam int PW = sng_pkg::PROD_W;
    localparam int AW = sng_pkg::ACC_W;

    localparam logic [MW-1:0] MEM_MAX  = {1'b0, {(MW-1){1'b1}}};
    localparam logic [MW-1:0] MEM_MIN  = {1'b1, {(MW-1){1'b0}}};
    localparam logic [MW-1:0] HALF_G   = {{(MW-GD){1'b0}}, 1'b1, {(GD-1){1'b0}}};
    localparam logic [PW-1:0] CEIL_ADD = {{(PW-CF){1'b0}}, {CF{1'b1}}};
    localparam logic [PW-1:0] HALF_Q   = {{(PW-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DIFF  = 12'b0000_0000_0010,
        S_MLO   = 12'b0000_0000_0100,
        S_MHI   = 12'b0000_0000_1000,
        S_ACC   = 12'b0000_0001_0000,
        S_APPLY = 12'b0000_0010_0000,
        S_HPOUT = 12'b0000_0100_0000,
        S_MAG   = 12'b0000_1000_0000,
        S_HYST  = 12'b0001_0000_0000,
        S_AUDIO = 12'b0010_0000_0000,
        S_ROUND = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    // Which smoothing update the step states are working on
    typedef enum logic [3:0] {
        ST_HP   = 4'b0001,
        ST_LP   = 4'b0010,
        ST_ENV  = 4'b0100,
        ST_GAIN = 4'b1000
    } t_stage;

    // Control and filter state
    t_state         r_state, n_state;
    t_stage         r_stage;
    logic [MW-1:0]  r_hpm;
    logic [MW-1:0]  r_lpm;
    logic [SW-1:0]  r_env;
    logic           r_open;
    logic [CW-1:0]  r_gain;

    // Per-item working registers
    logic [SW-1:0]  r_sc;
    logic [SW-1:0]  r_au;
    logic           r_auneg;
    logic [SW-1:0]  r_aumag;
    logic           r_byp;
    logic [MW-1:0]  r_x;
    logic [SW-1:0]  r_mag;
    logic           r_dneg;
    logic [DW-1:0]  r_dmag;
    logic [CW-1:0]  r_coef;
    logic           r_wide;
    logic [AW-1:0]  r_acc;

    // Combinational nets
    logic [DW-1:0]  w_xe;
    logic [DW-1:0]  w_opa, w_opb;
    logic [DW-1:0]  w_dab, w_dba;
    logic           w_dneg;
    logic [DW-1:0]  w_dmag;
    logic [CW-1:0]  w_cfirst, w_csecond, w_craw, w_coef;
    logic [DW-1:0]  w_upd;
    logic [MW-1:0]  w_mabs;
    logic           w_open_n;
    logic           w_mul_en;
    logic [UW-1:0]  w_mul_a, w_mul_b;
    logic [PW-1:0]  w_prod;
    logic [PW-1:0]  w_prod_ceil, w_prod_rnd;
    logic           w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign o_ready  = (r_state == S_IDLE);

    // Sidechain widened to the filter format
    assign w_xe = {r_sc[SW-1], r_sc, {GD{1'b0}}};

    // Operands of the current update: target and memory
    always_comb begin
        case (r_stage)
            ST_HP: begin
                w_opa     = w_xe;
                w_opb     = {r_hpm[MW-1], r_hpm};
                w_cfirst  = i_cfg.hp;
                w_csecond = i_cfg.hp;
            end
            ST_LP: begin
                w_opa     = {r_x[MW-1], r_x};
                w_opb     = {r_lpm[MW-1], r_lpm};
                w_cfirst  = i_cfg.lp;
                w_csecond = i_cfg.lp;
            end
            ST_ENV: begin
                w_opa     = {{(DW-SW){1'b0}}, r_mag};
                w_opb     = {{(DW-SW){1'b0}}, r_env};
                w_cfirst  = i_cfg.atk;
                w_csecond = i_cfg.rel;
            end
            ST_GAIN: begin
                w_opa     = r_open ? {{(DW-CW){1'b0}}, sng_pkg::ONE_COEF} : '0;
                w_opb     = {{(DW-CW){1'b0}}, r_gain};
                w_cfirst  = i_cfg.opn;
                w_csecond = i_cfg.cls;
            end
            default: begin
                w_opa     = '0;
                w_opb     = '0;
                w_cfirst  = '0;
                w_csecond = '0;
            end
        endcase
    end

    // Signed difference as sign and magnitude
    assign w_dab  = w_opa - w_opb;
    assign w_dba  = w_opb - w_opa;
    assign w_dneg = w_dab[DW-1];
    assign w_dmag = w_dneg ? w_dba : w_dab;

    // Falling direction uses the second coefficient; anything above 1.0 is 1.0
    assign w_craw = w_dneg ? w_csecond : w_cfirst;
    assign w_coef = (w_craw[CW-1] && (|w_craw[CW-2:0])) ? sng_pkg::ONE_COEF : w_craw;

    // Memory moved by the step magnitude toward its target
    assign w_upd = r_dneg ? (w_opb - r_acc[DW-1:0]) : (w_opb + r_acc[DW-1:0]);

    // Low-pass magnitude rounded to sample LSBs, ties away from zero
    assign w_mabs = r_lpm[MW-1] ? (HALF_G - r_lpm) : (r_lpm + HALF_G);

    // Hysteresis
    assign w_open_n = r_open ? !(r_env < sng_pkg::CLOSE_LEVEL)
                             : (r_env >= sng_pkg::OPEN_LEVEL);

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            S_MLO: begin
                w_mul_en = 1'b1;
                w_mul_a  = {{(UW-LW){1'b0}}, r_dmag[LW-1:0]};
                w_mul_b  = r_coef;
            end
            S_MHI: begin
                w_mul_en = 1'b1;
                w_mul_a  = {{(UW-(DW-LW)){1'b0}}, r_dmag[DW-1:LW]};
                w_mul_b  = r_coef;
            end
            S_AUDIO: begin
                w_mul_en = 1'b1;
                w_mul_a  = {{(UW-SW){1'b0}}, r_aumag};
                w_mul_b  = r_gain;
            end
            default: begin
                w_mul_en = 1'b0;
                w_mul_a  = '0;
                w_mul_b  = '0;
            end
        endcase
    end

    sng_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Low product rounded up; audio product rounded to nearest
    assign w_prod_ceil = w_prod + CEIL_ADD;
    assign w_prod_rnd  = w_prod + HALF_Q;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) begin
                n_state = i_cfg.enable ? S_DIFF : S_DONE;
            end
            S_DIFF:  n_state = S_MLO;
            S_MLO:   n_state = S_MHI;
            S_MHI:   n_state = r_wide ? S_ACC : S_APPLY;
            S_ACC:   n_state = S_APPLY;
            S_APPLY: begin
                case (r_stage)
                    ST_HP:   n_state = S_HPOUT;
                    ST_LP:   n_state = S_MAG;
                    ST_ENV:  n_state = S_HYST;
                    ST_GAIN: n_state = S_AUDIO;
                    default: n_state = S_IDLE;
                endcase
            end
            S_HPOUT: n_state = S_DIFF;
            S_MAG:   n_state = S_DIFF;
            S_HYST:  n_state = S_DIFF;
            S_AUDIO: n_state = S_ROUND;
            S_ROUND: n_state = S_DONE;
            S_DONE:  if (i_slot_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= ST_HP;
            r_hpm   <= '0;
            r_lpm   <= '0;
            r_env   <= '0;
            r_open  <= 1'b0;
            r_gain  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (w_accept) begin
                    r_stage <= ST_HP;
                end
                S_APPLY: begin
                    case (r_stage)
                        ST_HP:   r_hpm  <= w_upd[MW-1:0];
                        ST_LP:   r_lpm  <= w_upd[MW-1:0];
                        ST_ENV:  r_env  <= w_upd[SW-1:0];
                        ST_GAIN: r_gain <= w_upd[CW-1:0];
                        default: r_hpm  <= r_hpm;
                    endcase
                end
                S_HPOUT: r_stage <= ST_LP;
                S_MAG:   r_stage <= ST_ENV;
                S_HYST: begin
                    r_open  <= w_open_n;
                    r_stage <= ST_GAIN;
                end
                default: r_stage <= r_stage;
            endcase
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (w_accept) begin
                r_sc    <= i_sc;
                r_au    <= i_au;
                r_auneg <= i_au[SW-1];
                r_aumag <= i_au[SW-1] ? (SW'(0) - i_au) : i_au;
                r_byp   <= !i_cfg.enable;
            end
            S_DIFF: begin
                r_dneg <= w_dneg;
                r_dmag <= w_dmag;
                r_coef <= w_coef;
                // only the envelope difference fits the low slice; a full gain
                // swing of 1.0 needs the high one
                r_wide <= (r_stage != ST_ENV);
            end
            S_MHI:   r_acc <= AW'(w_prod_ceil[PW-1:CF]);
            S_ACC:   r_acc <= r_acc + w_prod[AW-1:0];
            S_HPOUT: begin
                // saturate the high-pass output to the sample range
                if (w_dab[DW-1] != w_dab[DW-2]) begin
                    r_x <= w_dab[DW-1] ? MEM_MIN : MEM_MAX;
                end else begin
                    r_x <= w_dab[MW-1:0];
                end
            end
            S_MAG:   r_mag <= w_mabs[MW-1:GD];
            S_ROUND: r_acc <= AW'(w_prod_rnd[PW-1:CF]);
            default: r_acc <= r_acc;
        endcase
    end

    // Result beat
    assign o_res.valid  = (r_state == S_DONE) && i_slot_free;
    assign o_res.open   = r_open;
    assign o_res.sample = r_byp   ? r_au :
                          r_auneg ? (SW'(0) - r_acc[SW-1:0]) : r_acc[SW-1:0];

endmodule

`default_nettype wire

// File: rtl/sidechain_noise_gate_unit.sv
// Sidechain noise gate with hysteresis. Each input beat carries a sidechain
// sample and an audio sample (signed Q1.23). The sidechain is high-passed,
// low-passed and fed to a peak envelope follower; a hysteresis flag opens at
// -60 dBFS and closes below -67 dBFS, the gain slews toward 1 or 0, and the
// audio leaves multiplied by that gain, rounded. With gate_enable clear the
// audio passes unchanged and the state holds. One 25x25 multiplier computes
// each product of a gated beat in turn under the sequencer; a bypassed
// beat goes straight from idle to the done state. After each result the
// sequencer returns to idle before it accepts again. The block takes one
// beat at a time and is not ready while it works; a finished result waits
// in the output register without holding up the next beat, and the result
// after it waits in the sequencer until that register frees.
// Write configuration only while the block is idle.
`default_nettype none

module sidechain_noise_gate_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // [23:0] sidechain_sample, [47:24] audio_sample
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [23:0] gated_sample
    output logic [0:0]       m_axis_tuser,   // [0] gate_is_open
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SW = sng_pkg::SAMPLE_W;
    localparam int CW = sng_pkg::COEF_W;
    localparam int DW = sng_pkg::CFG_DATA_W;
    localparam int IW = sng_pkg::REG_IDX_W;

    sng_pkg::t_cfg r_cfg;
    sng_pkg::t_res w_res;
    logic          r_ovalid;
    logic [SW-1:0] r_odata;
    logic          r_oopen;
    logic [IW-1:0] w_idx;
    logic          w_wr;
    logic          w_slot_free;

    // Register file
    assign pready = 1'b1;
    assign w_idx  = paddr[sng_pkg::CFG_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= sng_pkg::CFG_RESET;
        end else if (w_wr) begin
            case (w_idx)
                sng_pkg::REG_ENABLE: r_cfg.enable <= pwdata[0];
                sng_pkg::REG_HP:     r_cfg.hp     <= pwdata[CW-1:0];
                sng_pkg::REG_LP:     r_cfg.lp     <= pwdata[CW-1:0];
                sng_pkg::REG_ATK:    r_cfg.atk    <= pwdata[CW-1:0];
                sng_pkg::REG_REL:    r_cfg.rel    <= pwdata[CW-1:0];
                sng_pkg::REG_OPEN:   r_cfg.opn    <= pwdata[CW-1:0];
                sng_pkg::REG_CLOSE:  r_cfg.cls    <= pwdata[CW-1:0];
                default:             r_cfg        <= r_cfg;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (w_idx)
            sng_pkg::REG_ENABLE: prdata = {{(DW-1){1'b0}}, r_cfg.enable};
            sng_pkg::REG_HP:     prdata = {{(DW-CW){1'b0}}, r_cfg.hp};
            sng_pkg::REG_LP:     prdata = {{(DW-CW){1'b0}}, r_cfg.lp};
            sng_pkg::REG_ATK:    prdata = {{(DW-CW){1'b0}}, r_cfg.atk};
            sng_pkg::REG_REL:    prdata = {{(DW-CW){1'b0}}, r_cfg.rel};
            sng_pkg::REG_OPEN:   prdata = {{(DW-CW){1'b0}}, r_cfg.opn};
            sng_pkg::REG_CLOSE:  prdata = {{(DW-CW){1'b0}}, r_cfg.cls};
            default:             prdata = '0;
        endcase
    end

    // Output register frees up in the cycle its beat is taken
    assign w_slot_free = !r_ovalid || m_axis_tready;

    sng_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (s_axis_tvalid),
        .i_sc        (s_axis_tdata[SW-1:0]),
        .i_au        (s_axis_tdata[2*SW-1:SW]),
        .o_ready     (s_axis_tready),
        .i_slot_free (w_slot_free),
        .o_res       (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res.valid) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_odata <= w_res.sample;
            r_oopen <= w_res.open;
        end
    end

    assign m_axis_tvalid   = r_ovalid;
    assign m_axis_tdata    = r_odata;
    assign m_axis_tuser[0] = r_oopen;

`ifndef SYNTHESIS
    // An accepted beat keeps the sequencer busy on the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted again right after a beat");

    // A result is never written over a beat still waiting at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (!r_ovalid || m_axis_tready))
        else $error("result overwrote a pending output beat");

    // Results come only from a busy sequencer
    a_result_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> !s_axis_tready)
        else $error("result produced while idle");
`endif

endmodule

`default_nettype wire
